@@ rtl/edr_pkg.sv @@
package edr_pkg;

  localparam int MAX_WIDTH = 4096;
  localparam int MEM_DEPTH = MAX_WIDTH + 1;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  localparam int SAMPLE_W   = 16;
  localparam int ERR_W      = 16;
  localparam int PIXEL_W    = 12;
  localparam int LW_W       = 13;
  localparam int SD_W       = 5;
  localparam int TD_W       = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_DEPTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_DEPTH = 2'd2;

  localparam logic [LW_W-1:0] LINE_WIDTH_RST   = 13'd1920;
  localparam logic [SD_W-1:0] SOURCE_DEPTH_RST = 5'd10;
  localparam logic [TD_W-1:0] TARGET_DEPTH_RST = 4'd8;

  // What the address stage hands to the diffusion stage for one request.
  typedef struct packed {
    logic [ADDR_W-1:0]   col;
    logic                row_start;
    logic                vld_a;
    logic                vld_b;
    logic                fwd_a;
    logic                fwd_b;
    logic [SAMPLE_W-1:0] s16;
  } edr_s1_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [ERR_W-1:0]  data;
  } edr_wr_t;

  function automatic logic [ADDR_W-1:0] eff_width(input logic [LW_W-1:0] lw);
    logic [ADDR_W-1:0] w;
    if (lw == '0) begin
      w = ADDR_W'(1);
    end else if (int'(lw) > MAX_WIDTH) begin
      w = ADDR_W'(MAX_WIDTH);
    end else begin
      w = ADDR_W'(lw);
    end
    return w;
  endfunction

  // Left shift that brings a source sample up to 16 bits.
  function automatic logic [3:0] up_shift(input logic [SD_W-1:0] sd);
    logic [3:0] s;
    if (sd == '0) begin
      s = 4'd15;
    end else if (sd >= 5'd16) begin
      s = 4'd0;
    end else begin
      s = 4'(5'd16 - sd);
    end
    return s;
  endfunction

  function automatic logic [TD_W-1:0] tgt_clamp(input logic [TD_W-1:0] td);
    logic [TD_W-1:0] t;
    if (td < 4'd8) begin
      t = 4'd8;
    end else if (td > 4'd12) begin
      t = 4'd12;
    end else begin
      t = td;
    end
    return t;
  endfunction

endpackage

@@ rtl/edr_line_mem.sv @@
module edr_line_mem (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [edr_pkg::ADDR_W-1:0] rd_addr_a,
  input  logic [edr_pkg::ADDR_W-1:0] rd_addr_b,
  output logic [edr_pkg::ERR_W-1:0]  rd_data_a,
  output logic [edr_pkg::ERR_W-1:0]  rd_data_b,
  input  edr_pkg::edr_wr_t          wr
);
  import edr_pkg::*;

  logic [ERR_W-1:0] mem [MEM_DEPTH];
  logic [ERR_W-1:0] rd_data_a_r;
  logic [ERR_W-1:0] rd_data_b_r;

  // Reads return the old contents when a write hits the same entry.
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data_a_r <= mem[rd_addr_a];
      rd_data_b_r <= mem[rd_addr_b];
    end
  end

  assign rd_data_a = rd_data_a_r;
  assign rd_data_b = rd_data_b_r;

endmodule

@@ rtl/edr_addr_gen.sv @@
module edr_addr_gen (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [edr_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                         in_plane_start,
  input  logic [edr_pkg::LW_W-1:0]     line_width,
  input  logic [edr_pkg::SD_W-1:0]     source_depth,
  input  logic                         s1_adv,
  output logic                         s1_valid,
  output edr_pkg::edr_s1_t             s1,
  output logic                         rd_en,
  output logic [edr_pkg::ADDR_W-1:0]   rd_addr_a,
  output logic [edr_pkg::ADDR_W-1:0]   rd_addr_b
);
  import edr_pkg::*;

  logic [ADDR_W-1:0] w;
  logic              accept;
  logic [ADDR_W-1:0] col_cur;
  logic [ADDR_W-1:0] col_inc;
  logic [ADDR_W-1:0] col_r, col_nxt;
  logic [ADDR_W-1:0] fill_r, fill_nxt;
  logic              s1_valid_r, s1_valid_nxt;
  edr_s1_t           s1_r, s1_nxt;

  assign w        = eff_width(line_width);
  assign in_stall = s1_valid_r & ~s1_adv;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    if (in_plane_start || (col_r >= w)) begin
      col_cur = '0;
    end else begin
      col_cur = col_r;
    end
  end

  assign col_inc = col_cur + ADDR_W'(1);

  // Entries below the fill count were written in the current plane; the
  // rest read as zero. Columns only step by one or restart at zero, so the
  // written entries always form such a prefix.
  always_comb begin
    col_nxt  = col_r;
    fill_nxt = fill_r;
    if (accept) begin
      col_nxt = (col_inc >= w) ? '0 : col_inc;
      if (in_plane_start || (col_inc > fill_r)) begin
        fill_nxt = col_inc;
      end
    end
  end

  always_comb begin
    s1_nxt           = s1_r;
    s1_valid_nxt     = accept | (s1_valid_r & ~s1_adv);
    if (accept) begin
      s1_nxt.col       = col_cur;
      s1_nxt.row_start = (col_cur == '0);
      s1_nxt.vld_a     = ~in_plane_start & (col_cur < fill_r);
      s1_nxt.vld_b     = ~in_plane_start & (col_inc < fill_r);
      // The request now leaving the diffusion stage writes its entry at this
      // very edge, too late for the memory read; its error is taken from the
      // running error register instead. A new plane sees none of it.
      s1_nxt.fwd_a     = ~in_plane_start & s1_adv & (s1_r.col == col_cur);
      s1_nxt.fwd_b     = ~in_plane_start & s1_adv & (s1_r.col == col_inc);
      s1_nxt.s16       = in_sample << up_shift(source_depth);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      fill_r     <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      fill_r     <= fill_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
  end

  assign s1_valid  = s1_valid_r;
  assign s1        = s1_r;
  assign rd_en     = accept;
  assign rd_addr_a = col_cur;
  assign rd_addr_b = col_inc;

endmodule

@@ rtl/edr_diffuse.sv @@
module edr_diffuse (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        s1_valid,
  input  edr_pkg::edr_s1_t            s1,
  input  logic [edr_pkg::ERR_W-1:0]   rd_data_a,
  input  logic [edr_pkg::ERR_W-1:0]   rd_data_b,
  input  logic [edr_pkg::TD_W-1:0]    target_depth,
  output logic                        s1_adv,
  output edr_pkg::edr_wr_t            wr,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [edr_pkg::PIXEL_W-1:0] out_pixel
);
  import edr_pkg::*;

  logic [TD_W-1:0]    td;
  logic [3:0]         lsh;
  logic [3:0]         rsh;
  logic [19:0]        half;
  logic [PIXEL_W-1:0] pmax;
  logic [ERR_W-1:0]   err_a;
  logic [ERR_W-1:0]   err_b;
  logic [ERR_W-1:0]   run2;
  logic [ERR_W-1:0]   err_in;
  logic signed [19:0] v;
  logic [19:0]        v_sh;
  logic [PIXEL_W-1:0] pix;
  logic [ERR_W-1:0]   err_out;
  logic [ERR_W-1:0]   run_r;
  logic               out_valid_r, out_valid_nxt;
  logic [PIXEL_W-1:0] out_pixel_r;

  assign td   = tgt_clamp(target_depth);
  assign lsh  = 4'(5'd16 - {1'b0, td});
  assign rsh  = lsh + 4'd2;
  assign half = 20'd1 << (lsh + 4'd1);
  assign pmax = PIXEL_W'((13'd1 << td) - 13'd1);

  assign s1_adv = s1_valid & (~out_valid_r | ~out_stall);

  assign err_a = s1.fwd_a ? run_r : (s1.vld_a ? rd_data_a : '0);
  assign err_b = s1.fwd_b ? run_r : (s1.vld_b ? rd_data_b : '0);
  assign run2  = s1.row_start ? '0 : {run_r[ERR_W-2:0], 1'b0};

  // Errors wrap to 16 bits; the sample sum keeps enough bits to stay exact.
  assign err_in = run2 + err_a + err_b;
  assign v      = $signed({2'b00, s1.s16, 2'b00}) + $signed({{4{err_in[ERR_W-1]}}, err_in})
                  + $signed(half);
  assign v_sh   = $unsigned(v) >> rsh;

  always_comb begin
    if (v[19]) begin
      pix = '0;
    end else if (v_sh > {8'd0, pmax}) begin
      pix = pmax;
    end else begin
      pix = v_sh[PIXEL_W-1:0];
    end
  end

  assign err_out = s1.s16 - (ERR_W'({4'd0, pix}) << lsh);

  assign out_valid_nxt = s1_adv | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      run_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (s1_adv) begin
        run_r <= err_out;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_pixel_r <= pix;
    end
  end

  assign wr.we   = s1_adv;
  assign wr.addr = s1.col;
  assign wr.data = err_out;

  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;

endmodule

@@ rtl/error_diffusion_depth_reducer.sv @@
// Sierra-2-4A error diffusion from a 1 to 16 bit source down to 8 to 12 bits.
// The block takes one sample per clock while the result side does not stall
// and returns one pixel per sample: the address stage reads the errors above
// and above-right from the line store, then the diffusion stage closes the
// running-error loop and updates the store and the output register. The loop
// through the left neighbor's error sets the rate. A plane start clears the
// line store logically through a fill count, so no clearing pass is needed
// and the stream never pauses for it.
// Change the registers only while no request is in flight.
module error_diffusion_depth_reducer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [edr_pkg::SAMPLE_W-1:0]   in_sample,
  input  logic                           in_plane_start,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [edr_pkg::PIXEL_W-1:0]    out_pixel,
  input  logic                           cfg_we,
  input  logic [edr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [edr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import edr_pkg::*;

  logic [LW_W-1:0]   line_width_r;
  logic [SD_W-1:0]   source_depth_r;
  logic [TD_W-1:0]   target_depth_r;
  logic              s1_adv;
  logic              s1_valid;
  edr_s1_t           s1;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr_a;
  logic [ADDR_W-1:0] rd_addr_b;
  logic [ERR_W-1:0]  rd_data_a;
  logic [ERR_W-1:0]  rd_data_b;
  edr_wr_t           wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r   <= LINE_WIDTH_RST;
      source_depth_r <= SOURCE_DEPTH_RST;
      target_depth_r <= TARGET_DEPTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LINE_WIDTH:   line_width_r   <= cfg_wdata[LW_W-1:0];
        CFG_SOURCE_DEPTH: source_depth_r <= cfg_wdata[SD_W-1:0];
        CFG_TARGET_DEPTH: target_depth_r <= cfg_wdata[TD_W-1:0];
        default: ;
      endcase
    end
  end

  edr_addr_gen u_addr_gen (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample      (in_sample),
    .in_plane_start (in_plane_start),
    .line_width     (line_width_r),
    .source_depth   (source_depth_r),
    .s1_adv         (s1_adv),
    .s1_valid       (s1_valid),
    .s1             (s1),
    .rd_en          (rd_en),
    .rd_addr_a      (rd_addr_a),
    .rd_addr_b      (rd_addr_b)
  );

  edr_line_mem u_line_mem (
    .clk       (clk),
    .rd_en     (rd_en),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b),
    .wr        (wr)
  );

  edr_diffuse u_diffuse (
    .clk          (clk),
    .rst_n        (rst_n),
    .s1_valid     (s1_valid),
    .s1           (s1),
    .rd_data_a    (rd_data_a),
    .rd_data_b    (rd_data_b),
    .target_depth (target_depth_r),
    .s1_adv       (s1_adv),
    .wr           (wr),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_pixel    (out_pixel)
  );

endmodule

@@ rtl/edr_checker.sv @@
module edr_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [edr_pkg::PIXEL_W-1:0]    out_pixel
);

  // A stalled result stays put until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel))
    else $error("result changed while stalled");

  // The input side only backs up when a finished result is waiting.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with the output free");

  // An accepted request passes the address stage and then reaches the output
  // register unless the output side held it up.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 !out_stall |=> out_valid)
    else $error("accepted request did not produce a result");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("handshake not idle after reset");

endmodule

bind error_diffusion_depth_reducer edr_checker u_edr_checker (.*);

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import edr_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_ITEMS = 1700;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [SAMPLE_W-1:0] in_sample = '0;
  logic in_plane_start = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [PIXEL_W-1:0] out_pixel;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Shadow copy of the registers and of the diffusion state.
  logic [LW_W-1:0] shadow_lw;
  logic [SD_W-1:0] shadow_sd;
  logic [TD_W-1:0] shadow_td;
  logic signed [ERR_W-1:0] row_err [0:MAX_WIDTH];
  logic signed [ERR_W-1:0] left_err;
  int col_pos;

  logic [PIXEL_W-1:0] pixels_due [$];

  int n_mismatch = 0;
  int result_no = 0;
  int cycle_cnt = 0;
  int in_idle_pct = 15;
  int out_stall_pct = 15;
  int hold_req = 0;
  int hold_left = 0;

  error_diffusion_depth_reducer u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sample     (in_sample),
    .in_plane_start(in_plane_start),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pixel     (out_pixel),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int src_clamp(input logic [SD_W-1:0] sd);
    if (sd == '0) begin
      return 1;
    end else if (sd > 5'd16) begin
      return 16;
    end
    return int'(sd);
  endfunction

  // Works out the dithered pixel for one accepted request and queues it.
  task automatic predict_pixel(input logic [SAMPLE_W-1:0] smp, input logic ps);
    int w, sdc, tdc, up, lsh, half, pmax, s16, acc, v, pix;
    logic signed [ERR_W-1:0] e16;
    w = (shadow_lw == '0) ? 1 :
        (int'(shadow_lw) > MAX_WIDTH) ? MAX_WIDTH : int'(shadow_lw);
    sdc = src_clamp(shadow_sd);
    tdc = (shadow_td < 4'd8) ? 8 : (shadow_td > 4'd12) ? 12 : int'(shadow_td);
    up = 16 - sdc;
    lsh = 16 - tdc;
    half = 1 << (lsh + 1);
    pmax = (1 << tdc) - 1;
    if (ps) begin
      foreach (row_err[i]) row_err[i] = '0;
      col_pos = 0;
      left_err = '0;
    end
    if (col_pos >= w) col_pos = 0;
    if (col_pos == 0) left_err = '0;
    s16 = int'((32'(smp) << up) & 32'hFFFF);
    acc = 2 * int'(left_err) + int'(row_err[col_pos]) + int'(row_err[col_pos + 1]);
    e16 = acc[15:0];
    v = 4 * s16 + int'(e16) + half;
    if (v < 0) begin
      pix = 0;
    end else begin
      pix = v >> (lsh + 2);
      if (pix > pmax) pix = pmax;
    end
    e16 = 16'(s16 - (pix << lsh));
    row_err[col_pos] = e16;
    left_err = e16;
    col_pos++;
    if (col_pos >= w) col_pos = 0;
    pixels_due.push_back(PIXEL_W'(pix));
  endtask

  task automatic report_mismatch(input string what, input logic [PIXEL_W-1:0] got,
                                 input logic [PIXEL_W-1:0] want);
    $display("ERROR result %0d: %s, got %h, wanted %h", result_no, what, got, want);
    n_mismatch++;
  endtask

  always @(posedge clk) begin
    logic [PIXEL_W-1:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (pixels_due.size() == 0) begin
        report_mismatch("pixel with no request pending", out_pixel, '0);
      end else begin
        want = pixels_due.pop_front();
        if (out_pixel !== want) report_mismatch("pixel", out_pixel, want);
      end
      result_no++;
    end
  end

  // Result side: random stalls, now and then a long one, plus holds that a
  // test asks for.
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else if (out_stall_pct != 0 && $urandom_range(0, 99) < out_stall_pct) begin
      if ($urandom_range(0, 19) == 0) hold_left = $urandom_range(10, 40);
      out_stall = 1'b1;
    end else begin
      out_stall = 1'b0;
    end
  end

  function automatic int pick_gap();
    if (in_idle_pct == 0 || $urandom_range(0, 99) >= in_idle_pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // Entered and left at a falling edge; valid stays high into the next call.
  task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic ps);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_sample = smp;
    in_plane_start = ps;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_pixel(smp, ps);
    @(negedge clk);
  endtask

  task automatic drain_block();
    in_valid = 1'b0;
    while (pixels_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    drain_block();
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    case (idx)
      CFG_LINE_WIDTH:   shadow_lw = data[LW_W-1:0];
      CFG_SOURCE_DEPTH: shadow_sd = data[SD_W-1:0];
      CFG_TARGET_DEPTH: shadow_td = data[TD_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [SAMPLE_W-1:0] random_sample();
    int top;
    top = (1 << src_clamp(shadow_sd)) - 1;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return SAMPLE_W'($urandom);
      4, 5, 6, 7: return SAMPLE_W'($urandom_range(0, top));
      8: return SAMPLE_W'(top);
      default: return '0;
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_width();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return CFG_DATA_W'($urandom_range(1, 16));
    if (r < 9) return CFG_DATA_W'($urandom_range(17, 300));
    case ($urandom_range(0, 4))
      0: return '0;
      1: return CFG_DATA_W'(1);
      2: return CFG_DATA_W'(4095);
      3: return CFG_DATA_W'(4096);
      default: return CFG_DATA_W'(8191);
    endcase
  endfunction

  task automatic test_reset_values();
    send_sample(16'h0000, 1'b1);
    send_sample(16'h03FF, 1'b0);
    send_sample(16'hFFFF, 1'b0);
  endtask

  task automatic test_depth_limits();
    write_reg(CFG_LINE_WIDTH, 13'd3);
    write_reg(CFG_SOURCE_DEPTH, 13'd16);
    write_reg(CFG_TARGET_DEPTH, 13'd12);
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h8000, 1'b0);
    write_reg(CFG_SOURCE_DEPTH, 13'd9);
    write_reg(CFG_TARGET_DEPTH, 13'd8);
    send_sample(16'h01FF, 1'b1);
    send_sample(16'hFE00, 1'b0);
    send_sample(16'h0100, 1'b0);
    // Zero width, zero source depth and a too small target depth all clamp.
    write_reg(CFG_LINE_WIDTH, 13'd0);
    write_reg(CFG_SOURCE_DEPTH, 13'd0);
    write_reg(CFG_TARGET_DEPTH, 13'd0);
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'h0001, 1'b0);
    write_reg(CFG_LINE_WIDTH, 13'd8191);
    write_reg(CFG_SOURCE_DEPTH, 13'd31);
    write_reg(CFG_TARGET_DEPTH, 13'd15);
    send_sample(16'h7FFF, 1'b1);
    send_sample(16'hFFFF, 1'b0);
    // Equal source and target depths are dithered all the same.
    write_reg(CFG_SOURCE_DEPTH, 13'd12);
    write_reg(CFG_TARGET_DEPTH, 13'd12);
    send_sample(16'h0ABC, 1'b0);
    send_sample(16'h0FFF, 1'b0);
  endtask

  // A negative error left at a coarse target depth, then read back at a fine
  // one, drives the sum below zero and the pixel clips to zero.
  task automatic test_negative_sum();
    write_reg(CFG_LINE_WIDTH, 13'd1);
    write_reg(CFG_SOURCE_DEPTH, 13'd16);
    write_reg(CFG_TARGET_DEPTH, 13'd8);
    send_sample(16'h0080, 1'b1);
    write_reg(CFG_TARGET_DEPTH, 13'd12);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h0000, 1'b0);
  endtask

  task automatic test_row_wrap_and_shrink();
    write_reg(CFG_LINE_WIDTH, 13'd5);
    write_reg(CFG_SOURCE_DEPTH, 13'd10);
    write_reg(CFG_TARGET_DEPTH, 13'd10);
    send_sample(16'h0155, 1'b1);
    send_sample(16'h03FF, 1'b0);
    send_sample(16'h0001, 1'b0);
    // The column now lies past the new width, so the row starts over.
    write_reg(CFG_LINE_WIDTH, 13'd2);
    send_sample(16'h0200, 1'b0);
    send_sample(16'h0200, 1'b0);
    send_sample(16'h0100, 1'b0);
    send_sample(16'h02AA, 1'b1);
  endtask

  task automatic test_backpressure();
    drain_block();
    in_idle_pct = 0;
    out_stall_pct = 0;
    write_reg(CFG_LINE_WIDTH, 13'd16);
    hold_req = 300;
    for (int k = 0; k < 80; k++) send_sample(random_sample(), k == 0);
    drain_block();
  endtask

  task automatic test_drain_pause();
    in_idle_pct = 20;
    out_stall_pct = 20;
    for (int k = 0; k < 20; k++) send_sample(random_sample(), 1'b0);
    drain_block();
    for (int k = 0; k < 20; k++) send_sample(random_sample(), 1'b0);
  endtask

  task automatic test_random_stream();
    int sent, n;
    logic fresh_plane;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 7) write_reg(CFG_LINE_WIDTH, pick_width());
      if ($urandom_range(0, 9) < 5) begin
        write_reg(CFG_SOURCE_DEPTH, ($urandom_range(0, 9) < 7) ?
                  CFG_DATA_W'($urandom_range(9, 16)) : CFG_DATA_W'($urandom_range(0, 31)));
      end
      if ($urandom_range(0, 9) < 5) begin
        write_reg(CFG_TARGET_DEPTH, ($urandom_range(0, 9) < 8) ?
                  CFG_DATA_W'($urandom_range(8, 12)) : CFG_DATA_W'($urandom_range(0, 15)));
      end
      case ($urandom_range(0, 3))
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 20; out_stall_pct = 20; end
        2: begin in_idle_pct = 50; out_stall_pct = 10; end
        default: begin in_idle_pct = 10; out_stall_pct = 60; end
      endcase
      fresh_plane = ($urandom_range(0, 9) < 8);
      n = $urandom_range(20, 150);
      for (int k = 0; k < n; k++) begin
        send_sample(random_sample(),
                    (k == 0 && fresh_plane) || $urandom_range(0, 99) < 2);
      end
      sent += n;
    end
  endtask

  initial begin
    shadow_lw = LINE_WIDTH_RST;
    shadow_sd = SOURCE_DEPTH_RST;
    shadow_td = TARGET_DEPTH_RST;
    foreach (row_err[i]) row_err[i] = '0;
    left_err = '0;
    col_pos = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_values();
    test_depth_limits();
    test_negative_sum();
    test_row_wrap_and_shrink();
    test_backpressure();
    test_drain_pause();
    test_random_stream();
    drain_block();
    repeat (6) @(negedge clk);
    if (n_mismatch == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/edr_pkg.sv
rtl/edr_line_mem.sv
rtl/edr_addr_gen.sv
rtl/edr_diffuse.sv
rtl/error_diffusion_depth_reducer.sv
rtl/edr_checker.sv
tb/sv/tb.sv
